### rtl/aiq_pkg.sv
// Shared types and constants for the absmax int8 quantizer.
// No dependencies; imported by the core and its checker.
`default_nettype none

package aiq_pkg;

    localparam int SAMPLE_W  = 16;   // input sample width
    localparam int MAG_W     = 17;   // magnitude, holds 32768
    localparam int CODE_W    = 8;    // int8 code
    localparam int CMAG_W    = 7;    // code magnitude, 0..127
    localparam int DEQ_W     = 16;   // dequantized value
    localparam int NUM_W     = 22;   // widest dividend, 127 * 32768
    localparam int QUO_W     = 16;   // quotient shift register
    localparam int STEP_W    = 5;    // divider step counter

    localparam int CODE_STEPS = 8;   // quotient of x*127/max stays below 2^8
    localparam int DEQ_STEPS  = 16;  // quotient of code*max/127 stays below 2^16

    localparam logic [MAG_W-1:0]  QSCALE    = MAG_W'(127);
    localparam logic [CMAG_W-1:0] CODE_MAX  = 7'd127;
    localparam logic [DEQ_W-1:0]  DEQ_POS_MAX = 16'h7FFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD_CODE,
        S_DIV_CODE,
        S_ROUND_CODE,
        S_LOAD_DEQ,
        S_DIV_DEQ,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/absmax_int8_quantizer_core.sv
// After the last sample, each result goes through read, load, 8 divide steps, round, load,
// 16 divide steps and emit; an all-zero vector skips the divider and goes from load to emit.
// Loading accepts a sample on each start while idle; busy stays high for the whole output run,
// and the single restoring divider is shared by both divisions.
// Reset: synchronous active-low i_rst_n clears the sequencer, running max and fill count;
// the sample store is not cleared. Results cannot be stalled by the receiver.
`default_nettype none

module absmax_int8_quantizer_core
    import aiq_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire signed [SAMPLE_W-1:0]  i_sample,
    input  wire                        i_last,
    output logic                       o_valid,
    output logic signed [CODE_W-1:0]   o_code,
    output logic signed [DEQ_W-1:0]    o_dequant_value,
    output logic [SAMPLE_W-1:0]        o_abs_max,
    output logic                       o_run_end
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    // control
    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_len,   n_len;
    logic [CW-1:0]        r_idx,   n_idx;
    logic [MAG_W-1:0]     r_max,   n_max;
    logic [STEP_W-1:0]    r_step,  n_step;
    logic                 r_valid, n_valid;

    // datapath
    logic [SAMPLE_W-1:0]  r_mem [MAX_LEN];
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic [MAG_W-1:0]     r_rem,  n_rem;
    logic [QUO_W-1:0]     r_quo,  n_quo;
    logic [MAG_W-1:0]     r_den,  n_den;
    logic                 r_neg,  n_neg;
    logic [CMAG_W-1:0]    r_cmag, n_cmag;
    logic signed [CODE_W-1:0]   r_code, n_code;
    logic signed [DEQ_W-1:0]    r_deq,  n_deq;
    logic [SAMPLE_W-1:0]  r_amax, n_amax;
    logic                 r_end,  n_end;

    logic                 accept;
    logic                 store_ok;
    logic [MAG_W-1:0]     in_mag;
    logic [MAG_W-1:0]     rd_mag;
    logic [NUM_W-1:0]     num_code;
    logic [NUM_W-1:0]     num_deq;
    logic [MAG_W:0]       div_try;
    logic                 div_ge;
    logic [MAG_W:0]       two_rem;
    logic                 round_up;
    logic [CODE_W:0]      q_code;
    logic [QUO_W:0]       q_deq;
    logic                 last_elem;

    assign busy            = (r_state != S_IDLE);
    assign accept          = start && !busy;
    assign store_ok        = (r_count < CW'(MAX_LEN));
    assign o_valid         = r_valid;
    assign o_code          = r_code;
    assign o_dequant_value = r_deq;
    assign o_abs_max       = r_amax;
    assign o_run_end       = r_end;

    always_comb begin
        in_mag = i_sample[SAMPLE_W-1] ? (MAG_W'(0) - MAG_W'(i_sample)) : MAG_W'(i_sample);
        rd_mag = r_rd_data[SAMPLE_W-1] ? (MAG_W'(0) - MAG_W'(r_rd_data)) : MAG_W'(r_rd_data);
        num_code = NUM_W'({rd_mag, 7'b0} - {7'b0, rd_mag});
        num_deq  = NUM_W'(r_cmag) * NUM_W'(r_max);
        // one restoring step of the shared divider
        div_try  = {r_rem, r_quo[QUO_W-1]};
        div_ge   = (div_try >= {1'b0, r_den});
        // round half to even on the finished quotient
        two_rem  = {r_rem, 1'b0};
        round_up = (two_rem > {1'b0, r_den}) || ((two_rem == {1'b0, r_den}) && r_quo[0]);
        q_code   = {1'b0, r_quo[CODE_W-1:0]} + (CODE_W+1)'(round_up);
        q_deq    = {1'b0, r_quo} + (QUO_W+1)'(round_up);
        last_elem = ({1'b0, r_idx} + (CW+1)'(1)) == {1'b0, r_len};
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_len   = r_len;
        n_idx   = r_idx;
        n_max   = r_max;
        n_step  = r_step;
        n_valid = 1'b0;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        n_neg   = r_neg;
        n_cmag  = r_cmag;
        n_code  = r_code;
        n_deq   = r_deq;
        n_amax  = r_amax;
        n_end   = r_end;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (store_ok) begin
                        n_count = r_count + CW'(1);
                        if (in_mag > r_max) begin
                            n_max = in_mag;
                        end
                    end
                    if (i_last) begin
                        n_len   = store_ok ? (r_count + CW'(1)) : r_count;
                        n_idx   = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD_CODE;
            end
            S_LOAD_CODE: begin
                n_neg = r_rd_data[SAMPLE_W-1];
                if (r_max == '0) begin
                    // all-zero vector: skip the divider
                    n_cmag  = '0;
                    n_code  = '0;
                    n_rem   = '0;
                    n_quo   = '0;
                    n_den   = QSCALE;
                    n_state = S_EMIT;
                end else begin
                    n_rem   = MAG_W'(num_code[NUM_W-1:CODE_STEPS]);
                    n_quo   = {num_code[CODE_STEPS-1:0], (QUO_W-CODE_STEPS)'(0)};
                    n_den   = r_max;
                    n_step  = STEP_W'(CODE_STEPS - 1);
                    n_state = S_DIV_CODE;
                end
            end
            S_DIV_CODE, S_DIV_DEQ: begin
                n_rem  = div_ge ? MAG_W'(div_try - {1'b0, r_den}) : div_try[MAG_W-1:0];
                n_quo  = {r_quo[QUO_W-2:0], div_ge};
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = (r_state == S_DIV_CODE) ? S_ROUND_CODE : S_EMIT;
                end
            end
            S_ROUND_CODE: begin
                n_cmag  = (q_code > (CODE_W+1)'(CODE_MAX)) ? CODE_MAX : q_code[CMAG_W-1:0];
                n_state = S_LOAD_DEQ;
            end
            S_LOAD_DEQ: begin
                n_code  = r_neg ? (CODE_W'(0) - CODE_W'(r_cmag)) : CODE_W'(r_cmag);
                n_rem   = MAG_W'(num_deq[NUM_W-1:DEQ_STEPS]);
                n_quo   = num_deq[QUO_W-1:0];
                n_den   = QSCALE;
                n_step  = STEP_W'(DEQ_STEPS - 1);
                n_state = S_DIV_DEQ;
            end
            S_EMIT: begin
                if (r_max == '0) begin
                    n_deq = '0;
                end else if (r_neg) begin
                    n_deq = DEQ_W'((QUO_W+1)'(0) - q_deq);
                end else if (q_deq > (QUO_W+1)'(DEQ_POS_MAX)) begin
                    n_deq = DEQ_POS_MAX;
                end else begin
                    n_deq = q_deq[DEQ_W-1:0];
                end
                n_amax  = r_max[SAMPLE_W-1:0];
                n_end   = last_elem;
                n_valid = 1'b1;
                if (last_elem) begin
                    // close the vector, start fresh
                    n_max   = '0;
                    n_count = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_len   <= '0;
            r_idx   <= '0;
            r_max   <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_max   <= n_max;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_neg  <= n_neg;
        r_cmag <= n_cmag;
        r_code <= n_code;
        r_deq  <= n_deq;
        r_amax <= n_amax;
        r_end  <= n_end;
    end

    // sample store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && store_ok) begin
            r_mem[r_count[AW-1:0]] <= i_sample;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

### rtl/aiq_checker.sv
// Port-level checker for the absmax int8 quantizer core, bound to absmax_int8_quantizer_core.
// Depends on aiq_pkg for field widths.
`default_nettype none

module aiq_checker
    import aiq_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    input  wire                        busy,
    input  wire                        o_valid,
    input  wire signed [CODE_W-1:0]    o_code,
    input  wire signed [DEQ_W-1:0]     o_dequant_value,
    input  wire [SAMPLE_W-1:0]         o_abs_max,
    input  wire                        o_run_end
);

    // results only come out of an output run
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result transaction outside an output run");

    // more results pending: the block stays busy
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_run_end) |-> busy)
        else $error("block released before the run ended");

    // final result frees the block
    a_idle_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_run_end) |-> !busy)
        else $error("block still busy after the final result");

    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_abs_max == '0)) |-> ((o_code == '0) && (o_dequant_value == '0)))
        else $error("nonzero result for an all-zero vector");

    a_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_code == '0)) |-> (o_dequant_value == '0))
        else $error("zero code with nonzero dequantized value");

endmodule

bind absmax_int8_quantizer_core aiq_checker u_aiq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_code          (o_code),
    .o_dequant_value (o_dequant_value),
    .o_abs_max       (o_abs_max),
    .o_run_end       (o_run_end)
);

`default_nettype wire

### tb/tb.sv
// Self-checking bench for absmax_int8_quantizer_core: directed and random vectors,
// scored against an in-bench integer model of the absmax int8 quantizer.
// Depends on aiq_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
    import aiq_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic signed [CODE_W-1:0]   code;
        logic signed [DEQ_W-1:0]    deq;
        logic [SAMPLE_W-1:0]        amax;
        logic                       run_end;
    } t_quant_result;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       typed;
        logic signed [CODE_W-1:0]   code;
        logic signed [DEQ_W-1:0]    deq;
        logic [SAMPLE_W-1:0]        amax;
    } t_stim_row;

    localparam int NUM_DIRECTED = 18;
    localparam t_stim_row DIRECTED [NUM_DIRECTED] = '{
        // single-element vectors: result readable at a glance
        '{16'sd0,      1'b1, 1'b1, 8'sd0,    16'sd0,      16'd0},
        '{16'sd32767,  1'b1, 1'b1, 8'sd127,  16'sd32767,  16'd32767},
        '{16'sh8000,   1'b1, 1'b1, -8'sd127, 16'sh8000,   16'h8000},
        '{16'sd1,      1'b1, 1'b1, 8'sd127,  16'sd1,      16'd1},
        '{-16'sd1,     1'b1, 1'b1, -8'sd127, -16'sd1,     16'd1},
        // all-zero vector
        '{16'sd0,      1'b0, 1'b0, 8'sd0,    16'sd0,      16'd0},
        '{16'sd0,      1'b0, 1'b0, 8'sd0,    16'sd0,      16'd0},
        '{16'sd0,      1'b1, 1'b0, 8'sd0,    16'sd0,      16'd0},
        // code 127 against max 32768: dequant saturates
        '{16'sh8000,   1'b0, 1'b0, 8'sd0,    16'sd0,      16'd0},
        '{16'sd32767,  1'b1, 1'b0, 8'sd0,    16'sd0,      16'd0},
        // max 254: samples 1, 3, -1 land exactly on half codes
        '{16'sd254,    1'b0, 1'b0, 8'sd0,    16'sd0,      16'd0},
        '{16'sd1,      1'b0, 1'b0, 8'sd0,    16'sd0,      16'd0},
        '{16'sd3,      1'b0, 1'b0, 8'sd0,    16'sd0,      16'd0},
        '{-16'sd1,     1'b1, 1'b0, 8'sd0,    16'sd0,      16'd0},
        // alternating bit patterns 0x5555 and 0xAAAA, with -32767 and 100
        '{-16'sd32767, 1'b0, 1'b0, 8'sd0,    16'sd0,      16'd0},
        '{16'sh5555,   1'b0, 1'b0, 8'sd0,    16'sd0,      16'd0},
        '{16'shAAAA,   1'b0, 1'b0, 8'sd0,    16'sd0,      16'd0},
        '{16'sd100,    1'b1, 1'b0, 8'sd0,    16'sd0,      16'd0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_last;
    logic                       o_valid;
    logic signed [CODE_W-1:0]   o_code;
    logic signed [DEQ_W-1:0]    o_dequant_value;
    logic [SAMPLE_W-1:0]        o_abs_max;
    logic                       o_run_end;

    absmax_int8_quantizer_core #(
        .MAX_LEN(STORE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .o_code         (o_code),
        .o_dequant_value(o_dequant_value),
        .o_abs_max      (o_abs_max),
        .o_run_end      (o_run_end)
    );

    // model state
    int            vec_store [STORE_DEPTH];
    int            vec_max;
    int            vec_len;
    int            vec_raw;
    t_quant_result expected_codes [$];

    int idle_pct;
    int samples_sent;
    int vectors_done;
    int vectors_overfull;
    int results_checked;
    int failures;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_codes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint div_round_even(longint num, longint den);
        longint mag;
        longint q;
        longint r;
        mag = (num < 0) ? -num : num;
        q = mag / den;
        r = mag % den;
        if (2 * r > den || (2 * r == den && q % 2 == 1))
            q++;
        return (num < 0) ? -q : q;
    endfunction

    // Advance the model by one accepted sample; a last sample queues the whole run.
    function automatic void quantize_model(logic signed [SAMPLE_W-1:0] s, logic l);
        int            mag;
        longint        code;
        longint        deq;
        t_quant_result res;
        vec_raw++;
        if (vec_len < STORE_DEPTH) begin
            mag = (s < 0) ? -int'(s) : int'(s);
            vec_store[vec_len] = s;
            vec_len++;
            if (mag > vec_max)
                vec_max = mag;
        end
        if (!l)
            return;
        for (int i = 0; i < vec_len; i++) begin
            code = 0;
            deq = 0;
            if (vec_max > 0) begin
                code = div_round_even(longint'(vec_store[i]) * 127, vec_max);
                if (code > 127) code = 127;
                if (code < -128) code = -128;
                deq = div_round_even(code * vec_max, 127);
                if (deq > 32767) deq = 32767;
                if (deq < -32768) deq = -32768;
            end
            res.code = code[CODE_W-1:0];
            res.deq = deq[DEQ_W-1:0];
            res.amax = vec_max[SAMPLE_W-1:0];
            res.run_end = (i == vec_len - 1);
            expected_codes.push_back(res);
        end
        vectors_done++;
        if (vec_raw > STORE_DEPTH)
            vectors_overfull++;
        vec_max = 0;
        vec_len = 0;
        vec_raw = 0;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int mode);
        case (mode)
            0: return SAMPLE_W'($urandom);
            1: return $signed(SAMPLE_W'($urandom)) >>> $urandom_range(0, 15);
            2: return '0;
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'sh8000;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    4: return 16'sd1;
                    default: return SAMPLE_W'($urandom);
                endcase
            end
        endcase
    endfunction

    // Offer one transaction, hold it until accepted, then update the model.
    task automatic send_item(logic signed [SAMPLE_W-1:0] s, logic l);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_sample <= SAMPLE_W'($urandom);
            i_last <= 1'($urandom);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_sample <= s;
        i_last <= l;
        do @(posedge i_clk); while (busy);
        samples_sent++;
        quantize_model(s, l);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_quant_result got;
        t_quant_result want;
        if (i_rst_n && o_valid) begin
            got = '{o_code, o_dequant_value, o_abs_max, o_run_end};
            if (expected_codes.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("Unexpected result: code %0d deq %0d absmax %0d end %0b",
                             got.code, got.deq, got.amax, got.run_end);
            end else begin
                want = expected_codes.pop_front();
                results_checked++;
                if (got !== want) begin
                    failures++;
                    if (failures <= 10)
                        $display({"Mismatch: code %0d/%0d deq %0d/%0d absmax %0d/%0d ",
                                  "end %0b/%0b (got/expected)"},
                                 got.code, want.code, got.deq, want.deq,
                                 got.amax, want.amax, got.run_end, want.run_end);
                end
            end
        end
    end

    initial begin
        int phase_start;
        int len;
        int mode;
        int r;
        t_quant_result typed_res;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_sample = '0;
        i_last = 1'b0;
        vec_max = 0;
        vec_len = 0;
        vec_raw = 0;
        samples_sent = 0;
        vectors_done = 0;
        vectors_overfull = 0;
        results_checked = 0;
        failures = 0;
        cycles = 0;
        idle_pct = 33;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 33 : (phase == 1) ? 49 : 0;
            phase_start = samples_sent;
            if (phase == 0) begin
                foreach (DIRECTED[k]) begin
                    send_item(DIRECTED[k].sample, DIRECTED[k].last);
                    if (DIRECTED[k].typed) begin
                        // swap the computed entry for the hand-written one
                        void'(expected_codes.pop_back());
                        typed_res = '{DIRECTED[k].code, DIRECTED[k].deq,
                                      DIRECTED[k].amax, 1'b1};
                        expected_codes.push_back(typed_res);
                    end
                end
                // overfull vector: the dropped tail, last included, must not move the max
                for (int k = 0; k < STORE_DEPTH + 3; k++)
                    send_item((k < STORE_DEPTH) ? SAMPLE_W'($urandom_range(0, 2000)) - 16'sd1000
                                                : 16'sh8000,
                              k == STORE_DEPTH + 2);
            end
            while (samples_sent - phase_start < 157) begin
                r = $urandom_range(0, 99);
                len = (r < 5) ? $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8) :
                      (r < 15) ? $urandom_range(17, STORE_DEPTH) : $urandom_range(1, 16);
                r = $urandom_range(0, 99);
                mode = (r < 6) ? 2 : (r < 40) ? 0 : (r < 80) ? 1 : 3;
                for (int k = 0; k < len; k++)
                    send_item(pick_sample(mode), k == len - 1);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_codes.size() != 0) begin
            failures += expected_codes.size();
            $display("%0d expected results never arrived", expected_codes.size());
        end

        $display("Sent %0d samples in %0d vectors (%0d overfilled the store), %0d results checked",
                 samples_sent, vectors_done, vectors_overfull, results_checked);
        $display("Failures: %0d", failures);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/aiq_pkg.sv
rtl/absmax_int8_quantizer_core.sv
rtl/aiq_checker.sv
tb/tb.sv
